// ===== sv/sfc_pkg.sv =====
// Shared types and constants for the sensor frame checker.
// No dependencies; the other files that use it refer to it by scoped names.
package sfc_pkg;

    localparam int MaxFrameBytes = 1024;
    localparam int PosW          = $clog2(MaxFrameBytes + 2);
    localparam int LenW          = 16;
    localparam int CmpW          = LenW + 1;
    localparam int HeaderBytes   = 4;
    localparam int MinFrame      = 6;
    localparam int MinPayload    = 12;
    localparam int CaptureBytes  = 12;

    localparam logic [7:0] StartMark  = 8'hAA;
    localparam logic [7:0] SensorKind = 8'h02;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_BAD_START    = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_CHECKSUM_BAD = 3'd4,
        ST_WRONG_TYPE   = 3'd5,
        ST_PAYLOAD_SHORT = 3'd6
    } t_status;

    typedef struct packed {
        t_status     frame_status;
        logic [31:0] temperature_bits;
        logic [31:0] humidity_bits;
        logic [31:0] depth_bits;
    } t_result;

endpackage

// ===== sv/sfc_if.sv =====
// Valid/ready channel interfaces for datagram bytes and frame results.
// No dependencies.
interface sfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface sfc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_status;
    logic [31:0] temperature_bits;
    logic [31:0] humidity_bits;
    logic [31:0] depth_bits;

    modport source (output valid, output frame_status, output temperature_bits,
                    output humidity_bits, output depth_bits, input ready);
    modport sink   (input valid, input frame_status, input temperature_bits,
                    input humidity_bits, input depth_bits, output ready);
endinterface

// ===== sv/sfc_frame_tracker.sv =====
// Per-datagram header, checksum and capture state, plus the status decision.
// Depends on sfc_pkg.
module sfc_frame_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_datagram,
    output logic             o_result_valid,
    output sfc_pkg::t_result o_result
);

    localparam logic [sfc_pkg::PosW-1:0] PosSat = sfc_pkg::PosW'(sfc_pkg::MaxFrameBytes + 1);

    logic [sfc_pkg::PosW-1:0] r_pos;
    logic [7:0]               r_sum;
    logic                     r_start_ok;
    logic [7:0]               r_kind;
    logic [sfc_pkg::LenW-1:0] r_len;
    logic [7:0]               r_cap [sfc_pkg::CaptureBytes];

    logic                     n_start_ok;
    logic [7:0]               n_kind;
    logic [sfc_pkg::LenW-1:0] n_len;
    logic [sfc_pkg::PosW-1:0] total;
    logic [sfc_pkg::CmpW-1:0] total_ext;
    logic [sfc_pkg::CmpW-1:0] expected;
    sfc_pkg::t_status         status;

    // header fields as they stand once this byte is taken
    always_comb begin
        n_start_ok = r_start_ok;
        n_kind     = r_kind;
        n_len      = r_len;
        if (r_pos == sfc_pkg::PosW'(0)) begin
            n_start_ok = (i_data_byte == sfc_pkg::StartMark);
        end else if (r_pos == sfc_pkg::PosW'(1)) begin
            n_kind = i_data_byte;
        end else if (r_pos == sfc_pkg::PosW'(2)) begin
            n_len = {r_len[15:8], i_data_byte};
        end else if (r_pos == sfc_pkg::PosW'(3)) begin
            n_len = {i_data_byte, r_len[7:0]};
        end
    end

    always_comb begin
        total     = (r_pos == PosSat) ? PosSat : r_pos + 1'b1;
        total_ext = sfc_pkg::CmpW'(total);
        expected  = sfc_pkg::CmpW'(sfc_pkg::HeaderBytes + 1) + sfc_pkg::CmpW'(n_len);
        if (total < sfc_pkg::PosW'(sfc_pkg::MinFrame)) begin
            status = sfc_pkg::ST_SHORT;
        end else if (!n_start_ok) begin
            status = sfc_pkg::ST_BAD_START;
        end else if (total > sfc_pkg::PosW'(sfc_pkg::MaxFrameBytes) || total_ext != expected) begin
            status = sfc_pkg::ST_LEN_MISMATCH;
        end else if (r_sum != i_data_byte) begin
            status = sfc_pkg::ST_CHECKSUM_BAD;
        end else if (n_kind != sfc_pkg::SensorKind) begin
            status = sfc_pkg::ST_WRONG_TYPE;
        end else if (n_len < sfc_pkg::LenW'(sfc_pkg::MinPayload)) begin
            status = sfc_pkg::ST_PAYLOAD_SHORT;
        end else begin
            status = sfc_pkg::ST_OK;
        end
    end

    // a good frame has its final byte past the capture window, so stored bytes suffice
    always_comb begin
        o_result_valid        = i_accept && i_end_of_datagram;
        o_result.frame_status = status;
        if (status == sfc_pkg::ST_OK) begin
            o_result.temperature_bits = {r_cap[3], r_cap[2], r_cap[1], r_cap[0]};
            o_result.humidity_bits    = {r_cap[7], r_cap[6], r_cap[5], r_cap[4]};
            o_result.depth_bits       = {r_cap[11], r_cap[10], r_cap[9], r_cap[8]};
        end else begin
            o_result.temperature_bits = '0;
            o_result.humidity_bits    = '0;
            o_result.depth_bits       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else if (i_accept) begin
            if (i_end_of_datagram) begin
                r_pos <= '0;
                r_sum <= '0;
            end else begin
                if (r_pos != PosSat) begin
                    r_pos <= r_pos + 1'b1;
                end
                if (r_pos >= sfc_pkg::PosW'(sfc_pkg::HeaderBytes)) begin
                    r_sum <= r_sum + i_data_byte;
                end
            end
        end
    end

    // header and capture bytes are rewritten by every frame before they are used
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_start_ok <= n_start_ok;
            r_kind     <= n_kind;
            r_len      <= n_len;
            for (int k = 0; k < sfc_pkg::CaptureBytes; k++) begin
                if (r_pos == sfc_pkg::PosW'(k + sfc_pkg::HeaderBytes)) begin
                    r_cap[k] <= i_data_byte;
                end
            end
        end
    end

endmodule

// ===== sv/sfc_out_buffer.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on sfc_pkg and sfc_result_if.
module sfc_out_buffer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sfc_pkg::t_result i_result,
    output logic             o_ready,
    sfc_result_if.source     o_out
);

    logic             r_main_valid;
    logic             r_skid_valid;
    sfc_pkg::t_result r_main;
    sfc_pkg::t_result r_skid;
    logic             out_fire;
    logic             in_fire;

    assign o_ready  = !r_skid_valid;
    assign out_fire = r_main_valid && o_out.ready;
    assign in_fire  = i_valid && o_ready;

    assign o_out.valid            = r_main_valid;
    assign o_out.frame_status     = r_main.frame_status;
    assign o_out.temperature_bits = r_main.temperature_bits;
    assign o_out.humidity_bits    = r_main.humidity_bits;
    assign o_out.depth_bits       = r_main.depth_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire) begin
                if (!r_main_valid || out_fire) begin
                    r_main_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_main_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_main <= r_skid;
            end
        end else if (in_fire) begin
            if (!r_main_valid || out_fire) begin
                r_main <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without an output entry");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_main_valid && !o_out.ready) |=> r_skid_valid)
        else $error("result dropped while output stalled");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && o_out.ready) |=> (r_main_valid && !r_skid_valid))
        else $error("skid entry not moved to output");

endmodule

// ===== sv/sensor_frame_checker_unit.sv =====
// Sensor frame checker top level: byte channel in, one frame result per datagram out.
// Depends on sfc_pkg, sfc_if, sfc_frame_tracker and sfc_out_buffer.
//
// Usage:
//   i_in carries one datagram byte per beat with end_of_datagram on the last byte.
//   o_out carries one result beat per datagram: frame_status and, for a good
//   frame, the three little-endian float32 words as raw bits (zero otherwise).
//   Throughput: one byte per cycle while i_in.ready is high, set by the counter,
//   sum and capture update in the frame tracker.
//   Result path: the status is decided as the final byte is accepted, and the
//   result beat comes out of the output register (via the skid register on a stall).
//   Stall: a result waiting on o_out does not hold off input; bytes keep flowing,
//   and one more result lands in the skid register. i_in.ready drops only while
//   the skid register is full, and rises again once o_out takes a beat.
//   Reset (i_rst_n low, synchronous): byte count and payload sum clear, both
//   result entries empty; the next byte accepted is byte 0 of a new datagram.
//   A datagram longer than the maximum frame size saturates the byte count and
//   reports a length mismatch (a bad start mark takes priority).
module sensor_frame_checker_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sfc_byte_if.sink     i_in,
    sfc_result_if.source o_out
);

    logic             in_accept;
    logic             res_valid;
    sfc_pkg::t_result res;
    logic             buf_ready;

    // accept while the result buffer has room for one more frame result
    assign i_in.ready = buf_ready;
    assign in_accept  = i_in.valid && buf_ready;

    // track header, sum and capture; decide status on the final byte
    sfc_frame_tracker u_tracker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_data_byte       (i_in.data_byte),
        .i_end_of_datagram (i_in.end_of_datagram),
        .o_result_valid    (res_valid),
        .o_result          (res)
    );

    // hold results until the receiver takes them
    sfc_out_buffer u_out_buffer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_result (res),
        .o_ready  (buf_ready),
        .o_out    (o_out)
    );

endmodule
